// File: rtl/pcgd_pkg.sv
package pcgd_pkg;

  localparam int CH_W = 14;
  localparam int OUT_W = 8;
  localparam int THR_W = 6;

  localparam logic [CH_W-1:0] CH_MAX = 14'd16320;
  localparam logic [15:0] UNITY_GAIN = 16'd4096;
  localparam logic [15:0] NEAR_TOL = 16'd4;

  // BT.601 luma weights in Q0.16, with rounding.
  localparam int LUMA_R = 19595;
  localparam int LUMA_G = 38470;
  localparam int LUMA_B = 7471;
  localparam int LUMA_RND = 32768;

  localparam logic [2:0] REG_SAT_GAIN = 3'd0;
  localparam logic [2:0] REG_OVL_ALPHA = 3'd1;
  localparam logic [2:0] REG_OVL_RGB = 3'd2;
  localparam logic [2:0] REG_BRIGHT_GAIN = 3'd3;
  localparam logic [2:0] REG_WARM_RED = 3'd4;
  localparam logic [2:0] REG_WARM_BLUE = 3'd5;
  localparam logic [2:0] REG_BLACK_LIFT = 3'd6;

  // 8x8 Bayer thresholds, indexed by {row, col}.
  localparam logic [THR_W-1:0] BAYER [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  function automatic logic near_unity(input logic [15:0] g);
    logic [15:0] d;
    d = (g >= UNITY_GAIN) ? (g - UNITY_GAIN) : (UNITY_GAIN - g);
    return d <= NEAR_TOL;
  endfunction

  // Clamp to full scale, add the threshold and keep the integer part.
  // The clamp keeps the sum within 14 bits, so no saturation follows.
  function automatic logic [OUT_W-1:0] dither8(input logic [15:0] v,
                                               input logic [THR_W-1:0] thr);
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] s;
    c = (v > 16'(CH_MAX)) ? CH_MAX : v[CH_W-1:0];
    s = c + CH_W'(thr);
    return s[CH_W-1:THR_W];
  endfunction

endpackage

// File: rtl/pixel_color_grade_dither_unit.sv
// Color grading with 8x8 ordered dither. Each item is one BGRA pixel in
// unsigned Q8.6 with its column and row phase; it passes saturation about
// luma, an overlay blend capped at alpha, brightness gain, warmth gains on
// red and blue, a black-lift floor, and a Bayer dither down to 8 bits per
// channel. The datapath is a seven-stage pipeline that takes one pixel per
// clock while the output is not stalled. Each stage holds its item under
// backpressure and empty stages close up, so the input keeps taking items
// while a result waits. Registers should be written only while no pixels
// are in flight.
module pixel_color_grade_dither_unit
  import pcgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // blue_in[13:0], green_in[27:14], red_in[41:28], alpha_in[55:42],
  // col_phase[58:56], row_phase[61:59], zero fill [63:62]
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24]
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Channel order in all arrays: 0 blue, 1 green, 2 red, 3 alpha.
  logic [15:0] saturation_gain;
  logic [8:0]  overlay_alpha;
  logic [23:0] overlay_rgb;
  logic [15:0] brightness_gain;
  logic [13:0] warm_red_gain;
  logic [13:0] warm_blue_gain;
  logic [13:0] black_lift;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation_gain <= UNITY_GAIN;
      overlay_alpha <= '0;
      overlay_rgb <= '0;
      brightness_gain <= UNITY_GAIN;
      warm_red_gain <= 14'(UNITY_GAIN);
      warm_blue_gain <= 14'(UNITY_GAIN);
      black_lift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAT_GAIN:    saturation_gain <= cfg_data[15:0];
        REG_OVL_ALPHA:   overlay_alpha <= cfg_data[8:0];
        REG_OVL_RGB:     overlay_rgb <= cfg_data;
        REG_BRIGHT_GAIN: brightness_gain <= cfg_data[15:0];
        REG_WARM_RED:    warm_red_gain <= cfg_data[13:0];
        REG_WARM_BLUE:   warm_blue_gain <= cfg_data[13:0];
        REG_BLACK_LIFT:  black_lift <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  logic       sat_bypass;
  logic       bright_bypass;
  logic       ovl_en;
  logic [8:0] ovl_a;
  logic [8:0] ovl_inv;
  logic [7:0] ovl_k [3];

  always_comb begin
    sat_bypass = near_unity(saturation_gain);
    bright_bypass = near_unity(brightness_gain);
    ovl_en = (overlay_alpha != '0);
    ovl_a = (overlay_alpha > 9'd256) ? 9'd256 : overlay_alpha;
    ovl_inv = 9'd256 - ovl_a;
    ovl_k[0] = overlay_rgb[7:0];
    ovl_k[1] = overlay_rgb[15:8];
    ovl_k[2] = overlay_rgb[23:16];
  end

  // Stage valids and per-stage advance; an empty stage always takes.
  logic v1, v2, v3, v4, v5, v6, v7;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

  always_comb begin
    adv7 = !v7 || m_tready;
    adv6 = !v6 || adv7;
    adv5 = !v5 || adv6;
    adv4 = !v4 || adv5;
    adv3 = !v3 || adv4;
    adv2 = !v2 || adv3;
    adv1 = !v1 || adv2;
  end

  assign s_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
      if (adv6) v6 <= v5;
      if (adv7) v7 <= v6;
    end
  end

  // Stage 1: unpack, luma, dither threshold.
  logic [13:0] in_px [4];
  logic [30:0] luma_sum;
  logic [13:0] px1 [4];
  logic [13:0] luma1;
  logic [5:0]  thr1;
  logic        last1;

  always_comb begin
    in_px[0] = s_tdata[13:0];
    in_px[1] = s_tdata[27:14];
    in_px[2] = s_tdata[41:28];
    in_px[3] = s_tdata[55:42];
    luma_sum = 31'(in_px[2]) * 31'(LUMA_R) + 31'(in_px[1]) * 31'(LUMA_G)
             + 31'(in_px[0]) * 31'(LUMA_B) + 31'(LUMA_RND);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      px1 <= in_px;
      luma1 <= luma_sum[29:16];
      thr1 <= BAYER[{s_tdata[61:59], s_tdata[58:56]}];
      last1 <= s_tlast;
    end
  end

  // Stage 2: saturation products (c - luma) * gain.
  logic signed [14:0] sat_diff [3];
  logic signed [31:0] sprod2 [3];
  logic [13:0] px2 [4];
  logic [13:0] luma2;
  logic [5:0]  thr2;
  logic        last2;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat_diff[c] = $signed({1'b0, px1[c]}) - $signed({1'b0, luma1});
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int c = 0; c < 3; c++) begin
        sprod2[c] <= 32'(sat_diff[c]) * 32'($signed({1'b0, saturation_gain}));
      end
      px2 <= px1;
      luma2 <= luma1;
      thr2 <= thr1;
      last2 <= last1;
    end
  end

  // Stage 3: floor shift, add luma back, clamp; bypass keeps the input.
  logic signed [20:0] sat_sum [3];
  logic [13:0] sat_px [4];
  logic [13:0] px3 [4];
  logic [5:0]  thr3;
  logic        last3;

  always_comb begin
    sat_px[3] = px2[3];
    for (int c = 0; c < 3; c++) begin
      sat_sum[c] = 21'($signed(sprod2[c][31:12])) + 21'($signed({1'b0, luma2}));
      if (sat_bypass) begin
        sat_px[c] = px2[c];
      end else if (sat_sum[c][20]) begin
        sat_px[c] = '0;
      end else if (sat_sum[c][19:0] > 20'(CH_MAX)) begin
        sat_px[c] = CH_MAX;
      end else begin
        sat_px[c] = sat_sum[c][13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      px3 <= sat_px;
      thr3 <= thr2;
      last3 <= last2;
    end
  end

  // Stage 4: overlay blend sums.
  logic [21:0] osum4 [3];
  logic [13:0] px4 [4];
  logic [5:0]  thr4;
  logic        last4;

  always_ff @(posedge clk) begin
    if (adv4) begin
      for (int c = 0; c < 3; c++) begin
        osum4[c] <= 22'(px3[c]) * 22'(ovl_inv) + 22'({ovl_k[c], 6'b0}) * 22'(ovl_a);
      end
      px4 <= px3;
      thr4 <= thr3;
      last4 <= last3;
    end
  end

  // Stage 5: overlay scale and cap at alpha, then brightness products.
  logic [13:0] ovl_v [3];
  logic [13:0] ovl_px [4];
  logic [29:0] bprod5 [3];
  logic [13:0] px5 [4];
  logic [5:0]  thr5;
  logic        last5;

  always_comb begin
    ovl_px[3] = px4[3];
    for (int c = 0; c < 3; c++) begin
      ovl_v[c] = osum4[c][21:8];
      if (!ovl_en) begin
        ovl_px[c] = px4[c];
      end else if (ovl_v[c] < px4[3]) begin
        ovl_px[c] = ovl_v[c];
      end else begin
        ovl_px[c] = px4[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      for (int c = 0; c < 3; c++) begin
        bprod5[c] <= 30'(ovl_px[c]) * 30'(brightness_gain);
      end
      px5 <= ovl_px;
      thr5 <= thr4;
      last5 <= last4;
    end
  end

  // Stage 6: brightness clamp, then warmth products on red and blue.
  logic [17:0] bq [3];
  logic [13:0] br_px [3];
  logic [27:0] wred6;
  logic [27:0] wblue6;
  logic [13:0] green6;
  logic [13:0] alpha6;
  logic [5:0]  thr6;
  logic        last6;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bq[c] = bprod5[c][29:12];
      if (bright_bypass) begin
        br_px[c] = px5[c];
      end else if (bq[c] > 18'(CH_MAX)) begin
        br_px[c] = CH_MAX;
      end else begin
        br_px[c] = bq[c][13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv6) begin
      wred6 <= 28'(br_px[2]) * 28'(warm_red_gain);
      wblue6 <= 28'(br_px[0]) * 28'(warm_blue_gain);
      green6 <= br_px[1];
      alpha6 <= px5[3];
      thr6 <= thr5;
      last6 <= last5;
    end
  end

  // Stage 7: black-lift floor and dither into the output register.
  logic [15:0] red_w;
  logic [15:0] blue_w;
  logic [15:0] red_l;
  logic [15:0] green_l;
  logic [15:0] blue_l;
  logic [7:0]  blue_o, green_o, red_o, alpha_o;
  logic        last7;

  always_comb begin
    red_w = wred6[27:12];
    blue_w = wblue6[27:12];
    red_l = (red_w < 16'(black_lift)) ? 16'(black_lift) : red_w;
    blue_l = (blue_w < 16'(black_lift)) ? 16'(black_lift) : blue_w;
    green_l = (green6 < black_lift) ? 16'(black_lift) : 16'(green6);
  end

  always_ff @(posedge clk) begin
    if (adv7) begin
      blue_o <= dither8(blue_l, thr6);
      green_o <= dither8(green_l, thr6);
      red_o <= dither8(red_l, thr6);
      alpha_o <= dither8(16'(alpha6), thr6);
      last7 <= last6;
    end
  end

  assign m_tvalid = v7;
  assign m_tdata = {alpha_o, red_o, green_o, blue_o};
  assign m_tlast = last7;

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled although the output is taking items");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted item did not reach the first stage");

  a_stage6_holds: assert property (@(posedge clk) disable iff (rst)
    (v6 && !adv6) |=> (v6 && $stable(wred6) && $stable(green6)))
    else $error("stalled item in stage six was lost or changed");

  a_no_valid_after_reset: assert property (@(posedge clk)
    rst |=> (!v1 && !v4 && !m_tvalid))
    else $error("pipeline holds an item after reset");
`endif

endmodule
